/* hw/rtl/flc_pkg.sv */
// flc_pkg: widths, payload types and control struct of the FIR convolution core.
// No dependencies; imported by every other file of the block but flc_checker.
`default_nettype none
package flc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 34;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;
  // widest tap count the adder tree covers
  localparam int MAX_TAPS  = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // sequencer to tap chain
  typedef struct packed {
    logic step;       // chain advances this cycle
    logic zero_feed;  // tail flush: feed zero instead of the input sample
  } ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/flc_if.sv */
// flc_in_if / flc_out_if: valid/ready stream channels of the convolution core.
// Depends on flc_pkg for the payload types.
`default_nettype none
interface flc_in_if;
  import flc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface flc_out_if;
  import flc_pkg::*;
  logic valid;
  logic ready;
  acc_t conv_value;
  logic last_out;
  modport source (output valid, output conv_value, output last_out, input ready);
  modport sink   (input valid, input conv_value, input last_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fir_linear_convolution_core.sv */
// Channel | dir | transfer when       | payload
// in_ch   | in  | valid && ready      | sample (s16 Q12), last
// out_ch  | out | valid && ready      | conv_value (s34 Q24), last_out
// cfg     | in  | cfg_we              | cfg_index 0..4 = coef_0..coef_4, cfg_data
//
// One output per sample, one sample a cycle while the output is not stalled;
// a sample flagged last is followed by TAPS-1 tail outputs during which
// in_ch.ready is low. The result appears in the cycle after its sample is
// taken: it is formed from the registered sample chain. A stalled output
// freezes the whole chain and holds in_ch.ready low.
// Synchronous reset clears coefficients and the sample chain.
// Depends on flc_pkg, flc_if, flc_tap_cell and flc_ctrl.
`default_nettype none
module fir_linear_convolution_core #(
  parameter int TAPS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  flc_in_if.sink                 in_ch,
  flc_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire flc_pkg::cfg_idx_t cfg_index,
  input  wire flc_pkg::coef_t    cfg_data
);
  import flc_pkg::*;

  coef_t   coef_r [NUM_COEF];
  ctl_t    ctl;
  sample_t x;
  sample_t taps [TAPS+1];
  acc_t    term [MAX_TAPS];
  acc_t    sum_a [MAX_TAPS/2];
  acc_t    sum_b [MAX_TAPS/4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) coef_r[i] <= cfg_data;
      end
    end
  end

  flc_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_last  (out_ch.last_out),
    .out_ready (out_ch.ready),
    .ctl_o     (ctl)
  );

  assign x       = ctl.zero_feed ? sample_t'(0) : in_ch.sample;
  assign taps[0] = x;

  // samples move from cell 0 towards the far cell; products meet in a tree
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    if (k < TAPS) begin : g_cell
      coef_t c;
      prod_t p;
      if (k < NUM_COEF) begin : g_used
        assign c = coef_r[k];
      end else begin : g_zero
        assign c = '0;
      end
      flc_tap_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_i (ctl.step),
        .x_i    (taps[k]),
        .coef_i (c),
        .x_o    (taps[k+1]),
        .prod_o (p)
      );
      assign term[k] = ACC_W'(p);
    end else begin : g_pad
      assign term[k] = '0;
    end
  end

  // sums wrap at ACC_W bits
  for (genvar j = 0; j < MAX_TAPS/2; j++) begin : g_sum_a
    assign sum_a[j] = term[2*j] + term[2*j+1];
  end
  for (genvar j = 0; j < MAX_TAPS/4; j++) begin : g_sum_b
    assign sum_b[j] = sum_a[2*j] + sum_a[2*j+1];
  end

  assign out_ch.conv_value = sum_b[0] + sum_b[1];
endmodule
`default_nettype wire

/* hw/rtl/flc_tap_cell.sv */
// flc_tap_cell: one cell of the sample chain, holds one delayed sample, hands it
// to the next cell and forms coef * sample. Depends on flc_pkg.
`default_nettype none
module flc_tap_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire flc_pkg::sample_t x_i,
  input  wire flc_pkg::coef_t   coef_i,
  output flc_pkg::sample_t      x_o,
  output flc_pkg::prod_t        prod_o
);
  import flc_pkg::*;

  sample_t x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (step_i) begin
      x_r <= x_i;
    end
  end

  assign x_o    = x_r;
  assign prod_o = PROD_W'(coef_i) * PROD_W'(x_r);
endmodule
`default_nettype wire

/* hw/rtl/flc_ctrl.sv */
// flc_ctrl: handshake and tail-flush sequencer of the convolution core.
// Depends on flc_pkg; drives the tap chain through ctl_t.
`default_nettype none
module flc_ctrl #(
  parameter int TAPS = 5
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_last,
  input  wire logic  out_ready,
  output flc_pkg::ctl_t ctl_o
);
  import flc_pkg::*;

  localparam int CNT_W = $clog2(TAPS);
  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_r, last_nxt;
  logic             advance, in_fire, step;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance && (state_r == ST_RUN);
  assign in_fire  = in_ready && in_valid;
  assign step     = in_fire || (advance && (state_r == ST_FLUSH));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_RUN: begin
        if (in_fire && in_last) begin
          state_nxt = ST_FLUSH;
          cnt_nxt   = CNT_W'(TAPS - 1);
        end
      end
      ST_FLUSH: begin
        if (step) begin
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            last_nxt  = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last        = last_r;
  assign ctl_o.step      = step;
  assign ctl_o.zero_feed = (state_r == ST_FLUSH);
endmodule
`default_nettype wire

/* hw/rtl/flc_checker.sv */
// flc_checker: port-level assertions for the FIR convolution core, bound to
// fir_linear_convolution_core below. Depends on nothing else.
`default_nettype none
module flc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready
);

  // result held until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  // tail flush blocks input the cycle after a last sample
  a_flush_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken during tail flush");

  // stalled output freezes the chain, so no input is taken
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // an input transfer always produces a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind fir_linear_convolution_core flc_checker u_flc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire
